>>> rtl/core/lkv_pkg.sv
// Package for the linear key/value table: sizes, command and status codes, result type.
`default_nettype none

package lkv_pkg;

    // Table geometry
    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    // Field widths on the channels
    localparam int CMD_W     = 3;
    localparam int INDEX_W   = 7;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int FOUND_W   = 6;
    localparam int ECOUNT_W  = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_APPEND    = 3'd0;
    localparam t_cmd CMD_INSERT    = 3'd1;
    localparam t_cmd CMD_FIND_KEY  = 3'd2;
    localparam t_cmd CMD_FIND_VAL  = 3'd3;
    localparam t_cmd CMD_READ      = 3'd4;
    localparam t_cmd CMD_WRITE_KEY = 3'd5;
    localparam t_cmd CMD_WRITE_VAL = 3'd6;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_BAD_INDEX = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef struct packed {
        t_status              status;
        logic [FOUND_W-1:0]   found_index;
        logic [WORD_W-1:0]    found_key;
        logic [WORD_W-1:0]    found_value;
        logic [ECOUNT_W-1:0]  entry_count;
    } t_result;

    // Build a result word from table-side values
    function automatic t_result mk_res(
        input t_status                status,
        input logic [IDX_W-1:0]       idx,
        input logic [KEY_WIDTH-1:0]   key,
        input logic [VALUE_WIDTH-1:0] value,
        input logic [CNT_W-1:0]       count
    );
        t_result res;
        res.status      = status;
        res.found_index = FOUND_W'(idx);
        res.found_key   = WORD_W'(key);
        res.found_value = WORD_W'(value);
        res.entry_count = ECOUNT_W'(count);
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lkv_if.sv
// Channel interfaces of the linear key/value table: command in, result out.
`default_nettype none

interface lkv_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [lkv_pkg::CMD_W-1:0]   cmd;
    logic [lkv_pkg::INDEX_W-1:0] index;
    logic [lkv_pkg::WORD_W-1:0]  key;
    logic [lkv_pkg::WORD_W-1:0]  value;

    modport source (output valid, cmd, index, key, value, input ready);
    modport sink   (input valid, cmd, index, key, value, output ready);
endinterface

interface lkv_res_if;
    logic                         valid;
    logic                         ready;
    logic [lkv_pkg::STATUS_W-1:0] status;
    logic [lkv_pkg::FOUND_W-1:0]  found_index;
    logic [lkv_pkg::WORD_W-1:0]   found_key;
    logic [lkv_pkg::WORD_W-1:0]   found_value;
    logic [lkv_pkg::ECOUNT_W-1:0] entry_count;

    modport source (output valid, status, found_index, found_key, found_value, entry_count,
                    input ready);
    modport sink   (input valid, status, found_index, found_key, found_value, entry_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/linear_key_value_table.sv
// Linear key/value table: key and value memories, fill count and command sequencer.
//
//  channel  dir  payload                                              accept
//  i_cmd    in   cmd, index, key, value                               valid & ready
//  o_res    out  status, found_index, found_key, found_value, count   valid & ready
//
// One command at a time. Append, errors and unused codes go straight to S_DONE;
// read/write pass through S_RW, a search through S_SCAN and an insert through S_INS
// first, where the memories give one entry per cycle. S_DONE hands the result word
// to the output register when free, and a new command can then be taken at once.
// Reset empties the table (fill count zero); the memories are not cleared.
// A waiting result sits in the output register and does not block the next command.
`default_nettype none

module linear_key_value_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lkv_cmd_if.sink     i_cmd,
    lkv_res_if.source   o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RW   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int IW = lkv_pkg::IDX_W;
    localparam int CW = lkv_pkg::CNT_W;
    localparam int KW = lkv_pkg::KEY_WIDTH;
    localparam int VW = lkv_pkg::VALUE_WIDTH;

    // Storage
    logic [KW-1:0] key_mem [lkv_pkg::DEPTH];
    logic [VW-1:0] val_mem [lkv_pkg::DEPTH];
    logic [KW-1:0] r_rd_key;
    logic [VW-1:0] r_rd_val;

    logic [IW-1:0] mem_raddr;
    logic [IW-1:0] mem_waddr;
    logic          mem_wkey_en;
    logic          mem_wval_en;
    logic [KW-1:0] mem_wkey;
    logic [VW-1:0] mem_wval;

    // Control and payload registers
    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    logic [IW-1:0]          r_ptr, n_ptr;
    logic                   r_pend, n_pend;
    logic [IW-1:0]          r_idx, n_idx;
    lkv_pkg::t_cmd          r_cmd, n_cmd;
    logic [KW-1:0]          r_key, n_key;
    logic [VW-1:0]          r_val, n_val;
    lkv_pkg::t_result       r_res, n_res;
    lkv_pkg::t_result       r_out, n_out;

    logic          acc;
    logic          full;
    logic [KW-1:0] in_key;
    logic [VW-1:0] in_val;
    logic [IW-1:0] in_idx;
    logic          hit;
    logic [IW-1:0] ptr_dec;
    logic [KW-1:0] rw_key;
    logic [VW-1:0] rw_val;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == CW'(lkv_pkg::DEPTH));
    assign in_key      = KW'(i_cmd.key);
    assign in_val      = VW'(i_cmd.value);
    assign in_idx      = i_cmd.index[IW-1:0];
    assign ptr_dec     = r_ptr - IW'(1);
    assign hit         = (r_cmd == lkv_pkg::CMD_FIND_KEY) ? (r_rd_key == r_key)
                                                          : (r_rd_val == r_val);

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.found_index = r_out.found_index;
    assign o_res.found_key   = r_out.found_key;
    assign o_res.found_value = r_out.found_value;
    assign o_res.entry_count = r_out.entry_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_res.ready;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_val       = r_val;
        n_res       = r_res;
        n_out       = r_out;
        mem_raddr   = r_ptr;
        mem_waddr   = r_idx;
        mem_wkey_en = 1'b0;
        mem_wval_en = 1'b0;
        mem_wkey    = r_key;
        mem_wval    = r_val;
        rw_key      = r_rd_key;
        rw_val      = r_rd_val;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd   = i_cmd.cmd;
                    n_key   = in_key;
                    n_val   = in_val;
                    n_idx   = in_idx;
                    n_state = S_DONE;
                    case (i_cmd.cmd)
                        lkv_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_res = lkv_pkg::mk_res(lkv_pkg::ST_FULL, '0, '0, '0, r_count);
                            end else begin
                                mem_waddr   = r_count[IW-1:0];
                                mem_wkey    = in_key;
                                mem_wval    = in_val;
                                mem_wkey_en = 1'b1;
                                mem_wval_en = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_res       = lkv_pkg::mk_res(lkv_pkg::ST_OK, r_count[IW-1:0],
                                                              in_key, in_val, n_count);
                            end
                        end
                        lkv_pkg::CMD_INSERT: begin
                            if (32'(i_cmd.index) > 32'(r_count)) begin
                                n_res = lkv_pkg::mk_res(lkv_pkg::ST_BAD_INDEX, '0, '0, '0,
                                                        r_count);
                            end else if (full) begin
                                n_res = lkv_pkg::mk_res(lkv_pkg::ST_FULL, '0, '0, '0, r_count);
                            end else begin
                                // Shift from the top down; the read runs one entry ahead
                                n_ptr     = r_count[IW-1:0];
                                n_pend    = (r_count[IW-1:0] != in_idx);
                                mem_raddr = r_count[IW-1:0] - IW'(1);
                                n_state   = S_INS;
                            end
                        end
                        lkv_pkg::CMD_FIND_KEY, lkv_pkg::CMD_FIND_VAL: begin
                            if (r_count == '0) begin
                                n_res = lkv_pkg::mk_res(lkv_pkg::ST_NOT_FOUND, '0, '0, '0,
                                                        r_count);
                            end else begin
                                n_ptr     = '0;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        lkv_pkg::CMD_READ, lkv_pkg::CMD_WRITE_KEY, lkv_pkg::CMD_WRITE_VAL: begin
                            if (32'(i_cmd.index) >= 32'(r_count)) begin
                                n_res = lkv_pkg::mk_res(lkv_pkg::ST_BAD_INDEX, '0, '0, '0,
                                                        r_count);
                            end else begin
                                mem_raddr = in_idx;
                                n_state   = S_RW;
                            end
                        end
                        default: begin
                            n_res = lkv_pkg::mk_res(lkv_pkg::ST_OK, '0, '0, '0, r_count);
                        end
                    endcase
                end
            end

            S_INS: begin
                if (r_pend) begin
                    // Move the entry below up one place and fetch the next one down
                    mem_waddr   = r_ptr;
                    mem_wkey    = r_rd_key;
                    mem_wval    = r_rd_val;
                    mem_wkey_en = 1'b1;
                    mem_wval_en = 1'b1;
                    mem_raddr   = ptr_dec - IW'(1);
                    n_ptr       = ptr_dec;
                    n_pend      = (ptr_dec != r_idx);
                end else begin
                    mem_waddr   = r_idx;
                    mem_wkey_en = 1'b1;
                    mem_wval_en = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_res       = lkv_pkg::mk_res(lkv_pkg::ST_OK, r_idx, r_key, r_val,
                                                  n_count);
                    n_state     = S_DONE;
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_res   = lkv_pkg::mk_res(lkv_pkg::ST_OK, r_ptr, r_rd_key, r_rd_val,
                                              r_count);
                    n_state = S_DONE;
                end else if (CW'(r_ptr) + CW'(1) == r_count) begin
                    n_res   = lkv_pkg::mk_res(lkv_pkg::ST_NOT_FOUND, '0, '0, '0, r_count);
                    n_state = S_DONE;
                end else begin
                    n_ptr     = r_ptr + IW'(1);
                    mem_raddr = r_ptr + IW'(1);
                end
            end

            S_RW: begin
                if (r_cmd == lkv_pkg::CMD_WRITE_KEY) begin
                    mem_wkey_en = 1'b1;
                    rw_key      = r_key;
                end
                if (r_cmd == lkv_pkg::CMD_WRITE_VAL) begin
                    mem_wval_en = 1'b1;
                    rw_val      = r_val;
                end
                n_res   = lkv_pkg::mk_res(lkv_pkg::ST_OK, r_idx, rw_key, rw_val, r_count);
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hand the word to the output register once it is free
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_val <= n_val;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_wkey_en) begin
            key_mem[mem_waddr] <= mem_wkey;
        end
        if (mem_wval_en) begin
            val_mem[mem_waddr] <= mem_wval;
        end
        r_rd_key <= key_mem[mem_raddr];
        r_rd_val <= val_mem[mem_raddr];
    end

endmodule

`default_nettype wire
